[rtl/core/ps2_mouse_packet_tracker_assert.svh]
// Assertion macros shared by the tracker RTL.
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PS2MT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define PS2MT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/ps2mt_pkg.sv]
`timescale 1ns / 1ps

package ps2mt_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int POS_BITS    = 12;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LIMIT_W     = 12;
  localparam int RETRY_W     = 3;
  localparam int SUM_W       = POS_BITS + 2;

  localparam logic [7:0] NULL_BYTE     = 8'h00;
  localparam logic [7:0] ACK_BYTE      = 8'hFA;
  localparam logic [7:0] RESEND_BYTE   = 8'hFE;
  localparam int         X_SIGN_IDX    = 4;
  localparam int         Y_SIGN_IDX    = 5;
  localparam logic [7:0] OVERFLOW_MASK = 8'hC0;

  localparam logic [RETRY_W-1:0] RETRY_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_MAX  = '1;

  localparam logic [LIMIT_W-1:0] X_LIMIT_RST     = LIMIT_W'(79);
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST     = LIMIT_W'(24);
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = RETRY_W'(3);

  typedef enum logic [1:0] {
    REG_X_LIMIT     = 2'd0,
    REG_Y_LIMIT     = 2'd1,
    REG_RETRY_LIMIT = 2'd2
  } reg_index_t;

  // Per-word outcome of the command queue stage.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       dropped;
    logic       abandoned;
    logic       to_packet;
  } q_res_t;

  // Per-word outcome of the packet/cursor stage.
  typedef struct packed {
    logic                moved;
    logic [POS_BITS-1:0] pos_x;
    logic [POS_BITS-1:0] pos_y;
  } cur_res_t;

  // Limits wider than the position range saturate at the top position.
  function automatic logic [POS_BITS-1:0] sat_limit(input logic [LIMIT_W-1:0] limit);
    logic [POS_BITS-1:0] r;
    if (limit > LIMIT_W'(POS_MAX)) r = POS_MAX;
    else r = POS_BITS'(limit);
    return r;
  endfunction

  function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [SUM_W-1:0] r,
                                                   input logic [POS_BITS-1:0] lim);
    logic [POS_BITS-1:0] p;
    if (r < 0) p = '0;
    else if (r > $signed({2'b00, lim})) p = lim;
    else p = POS_BITS'(r);
    return p;
  endfunction

endpackage

[rtl/core/ps2mt_cmd_queue.sv]
`timescale 1ns / 1ps

module ps2mt_cmd_queue
  import ps2mt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               kind,
  input  logic [7:0]         data,
  input  logic [RETRY_W-1:0] retry_limit,
  output q_res_t             res
);

  logic [7:0]         store [QUEUE_DEPTH];
  logic [PTR_W-1:0]   head, head_next, head_inc;
  logic [PTR_W-1:0]   tail, tail_next, tail_inc;
  logic [CNT_W-1:0]   count, count_next;
  logic [RETRY_W-1:0] retry, retry_next;
  logic [PTR_W-1:0]   rd_addr;
  logic [7:0]         rd_data;
  logic               push;
  logic               resend_ok;

  assign head_inc  = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign tail_inc  = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
  assign resend_ok = (retry <= retry_limit);
  // One read port: resend repeats the head, ack/abandon fetches the one after it.
  assign rd_addr   = (data == RESEND_BYTE && resend_ok) ? head : head_inc;
  assign rd_data   = store[rd_addr];

  always_comb begin
    res        = '0;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    retry_next = retry;
    push       = 1'b0;
    if (kind) begin
      if (count >= CNT_W'(QUEUE_DEPTH)) begin
        res.dropped = 1'b1;
      end else begin
        if (count == '0) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = data;
        end
        push       = 1'b1;
        tail_next  = tail_inc;
        count_next = count + CNT_W'(1);
      end
    end else if (count != '0) begin
      case (data)
        NULL_BYTE: begin
        end
        ACK_BYTE: begin
          head_next  = head_inc;
          count_next = count - CNT_W'(1);
          retry_next = '0;
          if (count != CNT_W'(1)) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = rd_data;
          end
        end
        RESEND_BYTE: begin
          if (resend_ok) begin
            if (retry != RETRY_MAX) retry_next = retry + RETRY_W'(1);
            res.tx_valid = 1'b1;
            res.tx_byte  = rd_data;
          end else begin
            // Give up on the head and move straight on to the next command.
            head_next     = head_inc;
            count_next    = count - CNT_W'(1);
            retry_next    = '0;
            res.abandoned = 1'b1;
            if (count != CNT_W'(1)) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = rd_data;
            end
          end
        end
        default: res.to_packet = 1'b1;
      endcase
    end else begin
      res.to_packet = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      retry <= '0;
    end else if (fire) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      retry <= retry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && push) begin
      store[tail] <= data;
    end
  end

  `include "ps2_mouse_packet_tracker_assert.svh"

  `PS2MT_ASSERT(a_count_range, count <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `PS2MT_ASSERT(a_empty_ptrs, count == '0 |-> head == tail, "empty queue with head != tail")
  `PS2MT_ASSERT(a_drop_holds, fire && res.dropped |=> count == $past(count) && tail == $past(tail), "dropped command changed queue")

endmodule

[rtl/core/ps2mt_cursor.sv]
`timescale 1ns / 1ps

module ps2mt_cursor
  import ps2mt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               to_packet,
  input  logic [7:0]         data,
  input  logic [LIMIT_W-1:0] x_limit,
  input  logic [LIMIT_W-1:0] y_limit,
  output cur_res_t           res
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  phase_t              phase, phase_next;
  logic [7:0]          first_byte, first_byte_next;
  logic [7:0]          second_byte, second_byte_next;
  logic [POS_BITS-1:0] pos_x, pos_y;
  logic signed [SUM_W-1:0] dx, dy, sum_x, sum_y;

  // Nine-bit deltas: sign from the first byte, magnitude from the data bytes.
  assign dx    = SUM_W'($signed({first_byte[X_SIGN_IDX], second_byte}));
  assign dy    = -SUM_W'($signed({first_byte[Y_SIGN_IDX], data}));
  assign sum_x = $signed({2'b00, pos_x}) + dx;
  assign sum_y = $signed({2'b00, pos_y}) + dy;

  always_comb begin
    res              = '0;
    res.pos_x        = pos_x;
    res.pos_y        = pos_y;
    phase_next       = phase;
    first_byte_next  = first_byte;
    second_byte_next = second_byte;
    if (to_packet) begin
      case (phase)
        PH_SECOND: begin
          second_byte_next = data;
          phase_next       = PH_THIRD;
        end
        PH_THIRD: begin
          res.moved        = 1'b1;
          res.pos_x        = clamp_pos(sum_x, sat_limit(x_limit));
          res.pos_y        = clamp_pos(sum_y, sat_limit(y_limit));
          first_byte_next  = '0;
          second_byte_next = '0;
          phase_next       = PH_FIRST;
        end
        default: begin
          // Overflow flagged in a header byte: skip it, keep looking for a header.
          phase_next = PH_FIRST;
          if ((data & OVERFLOW_MASK) == '0) begin
            first_byte_next = data;
            phase_next      = PH_SECOND;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      first_byte  <= '0;
      second_byte <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      first_byte  <= first_byte_next;
      second_byte <= second_byte_next;
      pos_x       <= res.pos_x;
      pos_y       <= res.pos_y;
    end
  end

  `include "ps2_mouse_packet_tracker_assert.svh"

  `PS2MT_ASSERT(a_moved_third, fire && res.moved |-> phase == PH_THIRD && to_packet, "move outside third byte")
  `PS2MT_ASSERT(a_moved_clears, fire && res.moved |=> phase == PH_FIRST && first_byte == '0, "packet state not cleared after move")

endmodule

[rtl/core/ps2_mouse_packet_tracker.sv]
`timescale 1ns / 1ps

// PS/2 mouse packet tracker.
// Input channel (in_valid / in_stall): one word per item, kind selects a host
// command byte to queue (1) or a byte received from the mouse (0), in data_byte.
// Output channel (out_valid / out_stall): exactly one result word per input
// word: tx_valid/tx_byte (byte to send to the mouse now), moved with the
// clamped cursor_x/cursor_y, command_dropped (queue full) and command_abandoned.
// Config channel (cfg_valid / cfg_ready, always ready): cfg_index 0 x_limit,
// 1 y_limit, 2 retry_limit; other indexes are ignored. Write only when idle.
// An accepted word is held in the input register, then passes through the queue
// and cursor logic into the result register. Throughput: one word per cycle
// while the output is not stalled; the queue and cursor update their state as
// each word advances, so a new word can follow straight behind the last.
// A stalled result holds in the output register while the next word waits in
// the input register; only when both are full does in_stall rise.
// Reset (rst, synchronous): queue empty, retry count 0, cursor at 0,0, packet
// assembler awaiting a header byte, limits 79 / 24 / 3.
module ps2_mouse_packet_tracker
  import ps2mt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                tx_valid,
  output logic [7:0]          tx_byte,
  output logic                moved,
  output logic [POS_BITS-1:0] cursor_x,
  output logic [POS_BITS-1:0] cursor_y,
  output logic                command_dropped,
  output logic                command_abandoned,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [LIMIT_W-1:0]  cfg_data
);

  logic               in_q_valid;
  logic               kind_q;
  logic [7:0]         byte_q;
  logic               advance;
  logic               accept;
  logic [LIMIT_W-1:0] x_limit, y_limit;
  logic [RETRY_W-1:0] retry_limit;
  q_res_t             q_res;
  cur_res_t           c_res;

  // The held word moves on whenever the result register is free or draining.
  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      byte_q <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit     <= X_LIMIT_RST;
      y_limit     <= Y_LIMIT_RST;
      retry_limit <= RETRY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_LIMIT:     x_limit     <= cfg_data;
        REG_Y_LIMIT:     y_limit     <= cfg_data;
        REG_RETRY_LIMIT: retry_limit <= cfg_data[RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ps2mt_cmd_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .kind        (kind_q),
    .data        (byte_q),
    .retry_limit (retry_limit),
    .res         (q_res)
  );

  ps2mt_cursor u_cursor (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .to_packet (q_res.to_packet),
    .data      (byte_q),
    .x_limit   (x_limit),
    .y_limit   (y_limit),
    .res       (c_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_valid          <= q_res.tx_valid;
      tx_byte           <= q_res.tx_byte;
      command_dropped   <= q_res.dropped;
      command_abandoned <= q_res.abandoned;
      moved             <= c_res.moved;
      cursor_x          <= c_res.pos_x;
      cursor_y          <= c_res.pos_y;
    end
  end

  `include "ps2_mouse_packet_tracker_assert.svh"

  `PS2MT_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "stall with result free")
  `PS2MT_ASSERT(a_advance_loads, advance |=> out_valid, "advanced word produced no result")
  `PS2MT_ASSERT_ALWAYS(a_reset_empty, rst |=> !in_q_valid && !out_valid, "not empty after reset")

endmodule
